// ===== rtl/core/fmapf_pkg.sv =====
// Shared widths, codes and rule type for the first-match address/port filter.
`default_nettype none

package fmapf_pkg;

   localparam int ADDR_W    = 32;
   localparam int PORT_W    = 16;
   localparam int PREFIX_W  = 6;
   localparam int VERDICT_W = 2;
   localparam int SLOT_W    = 4;
   localparam int COUNT_W   = 5;

   // Longest meaningful prefix; longer values are clamped to it.
   localparam logic [PREFIX_W-1:0] FULL_PREFIX = 6'd32;

   localparam logic KIND_WRITE  = 1'b0;
   localparam logic KIND_LOOKUP = 1'b1;

   localparam logic [VERDICT_W-1:0] VERDICT_SKIP     = 2'd0;
   localparam logic [VERDICT_W-1:0] VERDICT_ACCEPT   = 2'd1;
   localparam logic [VERDICT_W-1:0] VERDICT_REFUSE   = 2'd2;
   localparam logic [VERDICT_W-1:0] VERDICT_RESERVED = 2'd3;

   typedef struct packed {
      logic [ADDR_W-1:0]    address;
      logic [PREFIX_W-1:0]  prefix;
      logic [PORT_W-1:0]    port;
      logic [VERDICT_W-1:0] verdict;
   } rule_type;

endpackage

`default_nettype wire

// ===== rtl/core/fmapf_channels.sv =====
// Handshake channels for request words, response words and the count register.
`default_nettype none

interface fmapf_req_if;
   import fmapf_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 kind;
   logic [SLOT_W-1:0]    rule_slot;
   logic [ADDR_W-1:0]    rule_address;
   logic [PREFIX_W-1:0]  rule_prefix;
   logic [PORT_W-1:0]    rule_port;
   logic [VERDICT_W-1:0] rule_verdict;
   logic [ADDR_W-1:0]    target_address;
   logic [PORT_W-1:0]    dest_port;

   modport source (
      output valid, kind, rule_slot, rule_address, rule_prefix, rule_port,
             rule_verdict, target_address, dest_port,
      input  ready
   );
   modport sink (
      input  valid, kind, rule_slot, rule_address, rule_prefix, rule_port,
             rule_verdict, target_address, dest_port,
      output ready
   );
endinterface

interface fmapf_rsp_if;
   import fmapf_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [VERDICT_W-1:0] verdict;
   logic                 matched;
   logic [SLOT_W-1:0]    match_slot;

   modport source (output valid, verdict, matched, match_slot, input ready);
   modport sink (input valid, verdict, matched, match_slot, output ready);
endinterface

interface fmapf_csr_if;
   import fmapf_pkg::*;

   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/fmapf_rule_match.sv =====
// Compare unit: tests one stored rule against the target address and port.
`default_nettype none

module fmapf_rule_match (
   input  fmapf_pkg::rule_type            rule,
   input  logic [fmapf_pkg::ADDR_W-1:0]   target_address,
   input  logic [fmapf_pkg::PORT_W-1:0]   dest_port,
   output logic                           hit
);
   import fmapf_pkg::*;

   logic [PREFIX_W-1:0] plen;
   logic [ADDR_W-1:0]   mask;
   logic                addr_hit;
   logic                port_hit;

   always_comb begin
      plen = (rule.prefix > FULL_PREFIX) ? FULL_PREFIX : rule.prefix;
      // A zero prefix masks every bit away, so it matches any address.
      if (plen == '0) begin
         mask = '0;
      end else begin
         mask = {ADDR_W{1'b1}} << (FULL_PREFIX - plen);
      end
      addr_hit = (((rule.address ^ target_address) & mask) == '0);
      port_hit = (rule.port == '0) || (rule.port == dest_port);
      hit      = addr_hit && port_hit;
   end

endmodule

`default_nettype wire

// ===== rtl/core/first_match_address_port_filter_core.sv =====
// Sequence: a rule write, or a lookup with a clamped count of zero, ends without a walk;
// other lookups walk rules in order to the first hit, or the clamped count (<= MAX_RULES).
// Throughput: one word at a time; the single compare unit walks the table one rule per cycle.
// Reset (synchronous, active high) clears the rule count, the sequencer and the response
// valid; the rule table itself is not cleared and holds garbage until each slot is written.
`default_nettype none

module first_match_address_port_filter_core #(
   parameter int MAX_RULES = 16
) (
   input  logic        clock,
   input  logic        reset,
   fmapf_req_if.sink   req_chan,
   fmapf_rsp_if.source rsp_chan,
   fmapf_csr_if.sink   csr_chan
);
   import fmapf_pkg::*;

   // Index width for the table, and a counter width that can also hold the
   // rule count register and the MAX_RULES limit itself.
   localparam int IDX_W     = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
   localparam int MEM_DEPTH = 2 ** IDX_W;
   localparam int CNT_BITS  = $clog2(MAX_RULES + 1);
   localparam int LIM_W     = (CNT_BITS > COUNT_W) ? CNT_BITS : COUNT_W;
   localparam logic [LIM_W-1:0] MAX_LIMIT = LIM_W'(MAX_RULES);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_HOLD
   } state_type;

   // Rule table: written on a rule-write word, read one slot per cycle
   // during a walk, with registered read data.
   rule_type table_mem [MEM_DEPTH];
   rule_type rd_rule_ff;
   logic [IDX_W-1:0] rd_addr;

   // Control and registered outputs.
   state_type            state_ff, state_in;
   logic [COUNT_W-1:0]   rule_count_ff, rule_count_in;
   logic [LIM_W-1:0]     limit_ff, limit_in;
   logic [LIM_W-1:0]     idx_ff, idx_in;
   logic [ADDR_W-1:0]    tgt_addr_ff, tgt_addr_in;
   logic [PORT_W-1:0]    tgt_port_ff, tgt_port_in;
   logic [VERDICT_W-1:0] res_verdict_ff, res_verdict_in;
   logic                 res_matched_ff, res_matched_in;
   logic [SLOT_W-1:0]    res_slot_ff, res_slot_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [VERDICT_W-1:0] rsp_verdict_ff, rsp_verdict_in;
   logic                 rsp_matched_ff, rsp_matched_in;
   logic [SLOT_W-1:0]    rsp_slot_ff, rsp_slot_in;

   logic                 req_accept;
   logic                 rsp_free;
   logic                 hit;
   logic [LIM_W-1:0]     count_ext;
   logic [LIM_W-1:0]     clamped_limit;
   logic [LIM_W-1:0]     slot_ext;
   logic [LIM_W-1:0]     idx_next;
   logic                 wr_en;
   rule_type             wr_rule;
   logic                 done;
   logic [VERDICT_W-1:0] done_verdict;
   logic                 done_matched;
   logic [SLOT_W-1:0]    done_slot;

   // The shared compare unit sees the rule read in the previous cycle.
   fmapf_rule_match u_match (
      .rule           (rd_rule_ff),
      .target_address (tgt_addr_ff),
      .dest_port      (tgt_port_ff),
      .hit            (hit)
   );

   // The count register is always writable, so software itself must write it only while idle.
   assign csr_chan.ready = 1'b1;
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.verdict    = rsp_verdict_ff;
   assign rsp_chan.matched    = rsp_matched_ff;
   assign rsp_chan.match_slot = rsp_slot_ff;

   always_comb begin
      count_ext     = LIM_W'(rule_count_ff);
      clamped_limit = (count_ext > MAX_LIMIT) ? MAX_LIMIT : count_ext;
      slot_ext      = LIM_W'(req_chan.rule_slot);
      idx_next      = idx_ff + LIM_W'(1);

      // A write with reserved verdict code three is stored as skip, and a
      // write to a slot at or above MAX_RULES is dropped.
      wr_en           = req_accept && (req_chan.kind == KIND_WRITE) && (slot_ext < MAX_LIMIT);
      wr_rule.address = req_chan.rule_address;
      wr_rule.prefix  = req_chan.rule_prefix;
      wr_rule.port    = req_chan.rule_port;
      wr_rule.verdict = (req_chan.rule_verdict == VERDICT_RESERVED) ? VERDICT_SKIP
                                                                    : req_chan.rule_verdict;
   end

   always_comb begin
      state_in       = state_ff;
      rule_count_in  = rule_count_ff;
      limit_in       = limit_ff;
      idx_in         = idx_ff;
      tgt_addr_in    = tgt_addr_ff;
      tgt_port_in    = tgt_port_ff;
      res_verdict_in = res_verdict_ff;
      res_matched_in = res_matched_ff;
      res_slot_in    = res_slot_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_verdict_in = rsp_verdict_ff;
      rsp_matched_in = rsp_matched_ff;
      rsp_slot_in    = rsp_slot_ff;
      rd_addr        = '0;
      done           = 1'b0;
      done_verdict   = VERDICT_SKIP;
      done_matched   = 1'b0;
      done_slot      = '0;

      if (csr_chan.valid) begin
         rule_count_in = csr_chan.data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               tgt_addr_in = req_chan.target_address;
               tgt_port_in = req_chan.dest_port;
               limit_in    = clamped_limit;
               idx_in      = '0;
               // Slot 0 is read now so the first compare happens next cycle.
               rd_addr     = '0;
               if ((req_chan.kind == KIND_WRITE) || (clamped_limit == '0)) begin
                  done = 1'b1;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // Fetch the following slot while the current one is compared.
            rd_addr = idx_next[IDX_W-1:0];
            idx_in  = idx_next;
            if (hit) begin
               done         = 1'b1;
               done_verdict = rd_rule_ff.verdict;
               done_matched = 1'b1;
               done_slot    = idx_ff[SLOT_W-1:0];
            end else if (idx_next == limit_ff) begin
               done = 1'b1;
            end
         end
         ST_HOLD: begin
            done         = 1'b1;
            done_verdict = res_verdict_ff;
            done_matched = res_matched_ff;
            done_slot    = res_slot_ff;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // A finished result goes straight to the output register when it is
      // free, and otherwise parks until the consumer takes the previous word.
      if (done) begin
         if (rsp_free) begin
            rsp_valid_in   = 1'b1;
            rsp_verdict_in = done_verdict;
            rsp_matched_in = done_matched;
            rsp_slot_in    = done_slot;
            state_in       = ST_IDLE;
         end else begin
            res_verdict_in = done_verdict;
            res_matched_in = done_matched;
            res_slot_in    = done_slot;
            state_in       = ST_HOLD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rule_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rule_count_ff <= rule_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      limit_ff       <= limit_in;
      idx_ff         <= idx_in;
      tgt_addr_ff    <= tgt_addr_in;
      tgt_port_ff    <= tgt_port_in;
      res_verdict_ff <= res_verdict_in;
      res_matched_ff <= res_matched_in;
      res_slot_ff    <= res_slot_in;
      rsp_verdict_ff <= rsp_verdict_in;
      rsp_matched_ff <= rsp_matched_in;
      rsp_slot_ff    <= rsp_slot_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[slot_ext[IDX_W-1:0]] <= wr_rule;
      end
      rd_rule_ff <= table_mem[rd_addr];
   end

endmodule

`default_nettype wire

// ===== bench/tb_first_match_address_port_filter_core.sv =====
// Self-checking testbench for the first-match address/port filter core.
module tb_first_match_address_port_filter_core;
   import fmapf_pkg::*;

   // The core under test is built with the default table of sixteen rules.
   localparam int RULE_SLOTS   = 16;
   localparam int IDLE_PERCENT = 21;
   // The longest lookup walks every rule once after it is accepted, so
   // SETTLE_CYCLES of quiet after the last response is more than enough.
   localparam int SETTLE_CYCLES = 20;
   localparam int TIMEOUT_UNITS = 5_000_000;
   localparam int REPORT_LIMIT  = 10;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // One request word as the sender sees it.
   typedef struct packed {
      logic                 kind;
      logic [SLOT_W-1:0]    rule_slot;
      logic [ADDR_W-1:0]    rule_address;
      logic [PREFIX_W-1:0]  rule_prefix;
      logic [PORT_W-1:0]    rule_port;
      logic [VERDICT_W-1:0] rule_verdict;
      logic [ADDR_W-1:0]    target_address;
      logic [PORT_W-1:0]    dest_port;
   } request_word_type;

   // One response word as the receiver sees it.
   typedef struct packed {
      logic [VERDICT_W-1:0] verdict;
      logic                 matched;
      logic [SLOT_W-1:0]    match_slot;
   } verdict_word_type;

   logic clock = 1'b0;
   logic reset;

   fmapf_req_if req_chan ();
   fmapf_rsp_if rsp_chan ();
   fmapf_csr_if csr_chan ();

   first_match_address_port_filter_core #(
      .MAX_RULES(RULE_SLOTS)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .csr_chan(csr_chan)
   );

   // The bench keeps its own copy of the rule table and of the rule count.
   // Every response the core should give is queued here, oldest first.
   rule_type           shadow_rules [RULE_SLOTS];
   logic [COUNT_W-1:0] shadow_count;
   verdict_word_type   expected_verdicts [$];
   int unsigned        failures;
   // While this is set neither side idles, so words stream back to back.
   bit                 burst_mode;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Prefix lengths above a full address are treated as a full address.
   function automatic logic [PREFIX_W-1:0] clamp_prefix(input logic [PREFIX_W-1:0] plen);
      return (plen > FULL_PREFIX) ? FULL_PREFIX : plen;
   endfunction

   // A zero prefix matches any address. Otherwise only the leading plen bits
   // are compared, which keeps the shift below the address width.
   function automatic bit prefix_hits(input logic [ADDR_W-1:0]   rule_address,
                                      input logic [PREFIX_W-1:0] rule_prefix,
                                      input logic [ADDR_W-1:0]   target);
      logic [PREFIX_W-1:0] plen;
      plen = clamp_prefix(rule_prefix);
      if (plen == '0) return 1'b1;
      return ((rule_address ^ target) >> (ADDR_W - plen)) == '0;
   endfunction

   // Computes the response that the core owes for one accepted word, and
   // applies a rule write to the shadow table on the way.
   function automatic verdict_word_type predict_verdict(input request_word_type w);
      verdict_word_type result;
      int               limit;
      result = '0;
      if (w.kind == KIND_WRITE) begin
         // The reserved verdict code is stored as skip.
         shadow_rules[w.rule_slot].address = w.rule_address;
         shadow_rules[w.rule_slot].prefix  = w.rule_prefix;
         shadow_rules[w.rule_slot].port    = w.rule_port;
         shadow_rules[w.rule_slot].verdict =
            (w.rule_verdict == VERDICT_RESERVED) ? VERDICT_SKIP : w.rule_verdict;
         return result;
      end
      // A rule count above the table size consults the whole table.
      limit = (shadow_count > RULE_SLOTS) ? RULE_SLOTS : int'(shadow_count);
      for (int i = 0; i < limit; i++) begin
         if (prefix_hits(shadow_rules[i].address, shadow_rules[i].prefix, w.target_address) &&
             (shadow_rules[i].port == '0 || shadow_rules[i].port == w.dest_port)) begin
            // The first hit ends the walk, even when its verdict is skip.
            result.verdict    = shadow_rules[i].verdict;
            result.matched    = 1'b1;
            result.match_slot = SLOT_W'(i);
            return result;
         end
      end
      return result;
   endfunction

   // A rule write word; the target fields carry noise that the core ignores.
   function automatic request_word_type rule_word(input int unsigned slot,
                                                  input logic [ADDR_W-1:0] address,
                                                  input logic [PREFIX_W-1:0] prefix,
                                                  input logic [PORT_W-1:0] port,
                                                  input logic [VERDICT_W-1:0] verdict);
      request_word_type w;
      w.kind           = KIND_WRITE;
      w.rule_slot      = SLOT_W'(slot);
      w.rule_address   = address;
      w.rule_prefix    = prefix;
      w.rule_port      = port;
      w.rule_verdict   = verdict;
      w.target_address = $urandom;
      w.dest_port      = PORT_W'($urandom);
      return w;
   endfunction

   // A lookup word; the rule fields carry noise that the core ignores.
   function automatic request_word_type lookup_word(input logic [ADDR_W-1:0] address,
                                                    input logic [PORT_W-1:0] port);
      request_word_type w;
      w.kind           = KIND_LOOKUP;
      w.rule_slot      = SLOT_W'($urandom);
      w.rule_address   = $urandom;
      w.rule_prefix    = PREFIX_W'($urandom);
      w.rule_port      = PORT_W'($urandom);
      w.rule_verdict   = VERDICT_W'($urandom);
      w.target_address = address;
      w.dest_port      = port;
      return w;
   endfunction

   // Random traffic once every slot holds a rule. Most lookups are aimed at
   // a stored rule, keeping its prefix and usually its port, so that walks
   // end at every depth of the table; the rest are plain noise. Rule
   // addresses often share one network so that rules shadow each other.
   function automatic request_word_type random_word();
      request_word_type    w;
      rule_type            aim;
      logic [ADDR_W-1:0]   host_mask;
      logic [PORT_W-1:0]   port;
      case ($urandom_range(3))
         0, 1:    port = '0;
         2:       port = 16'd80;
         default: port = PORT_W'($urandom);
      endcase
      if ($urandom_range(99) < 30) begin
         w = rule_word($urandom_range(RULE_SLOTS - 1),
                       ($urandom_range(1) == 0) ? {8'd10, 24'($urandom)} : $urandom,
                       PREFIX_W'($urandom_range(63)), port,
                       VERDICT_W'($urandom_range(3)));
         // Give zero and over-long prefixes a fair share.
         case ($urandom_range(3))
            0:       w.rule_prefix = '0;
            1:       w.rule_prefix = PREFIX_W'($urandom_range(63, 33));
            default: w.rule_prefix = PREFIX_W'($urandom_range(32, 1));
         endcase
         return w;
      end
      w = lookup_word($urandom, PORT_W'($urandom));
      if ($urandom_range(99) < 75) begin
         aim       = shadow_rules[SLOT_W'($urandom_range(RULE_SLOTS - 1))];
         host_mask = {ADDR_W{1'b1}} >> clamp_prefix(aim.prefix);
         w.target_address = (aim.address & ~host_mask) | (w.target_address & host_mask);
         if (aim.port != '0 && $urandom_range(99) < 80) w.dest_port = aim.port;
      end
      return w;
   endfunction

   task automatic flag_failure(input string message);
      failures++;
      if (failures <= REPORT_LIMIT) $display("%s", message);
   endtask

   // Offers one word after an optional random gap and returns at the edge
   // where it is taken. Valid stays high, so a following word can go out
   // without a bubble.
   task automatic send_word(input request_word_type w);
      while (!burst_mode && $urandom_range(99) < IDLE_PERCENT) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid          <= 1'b1;
      req_chan.kind           <= w.kind;
      req_chan.rule_slot      <= w.rule_slot;
      req_chan.rule_address   <= w.rule_address;
      req_chan.rule_prefix    <= w.rule_prefix;
      req_chan.rule_port      <= w.rule_port;
      req_chan.rule_verdict   <= w.rule_verdict;
      req_chan.target_address <= w.target_address;
      req_chan.dest_port      <= w.dest_port;
      @(posedge clock);
      while (req_chan.ready !== 1'b1) @(posedge clock);
      expected_verdicts.push_back(predict_verdict(w));
   endtask

   // Stops offering words and waits until every owed response is back.
   // Since every word is answered, the core is idle from then on.
   task automatic wait_for_verdicts();
      req_chan.valid <= 1'b0;
      while (expected_verdicts.size() != 0) @(posedge clock);
   endtask

   // The rule count is only changed while the core is idle.
   task automatic write_rule_count(input logic [COUNT_W-1:0] count);
      wait_for_verdicts();
      csr_chan.valid <= 1'b1;
      csr_chan.data  <= count;
      @(posedge clock);
      while (csr_chan.ready !== 1'b1) @(posedge clock);
      csr_chan.valid <= 1'b0;
      shadow_count = count;
   endtask

   // With the reset count of zero no rule is consulted, so lookups miss even
   // though the table has never been written.
   task automatic test_empty_table();
      send_word(lookup_word('0, '0));
      send_word(lookup_word('1, '1));
   endtask

   // Fills every slot, so that any later rule count reads written entries.
   // The fixed rules cover a port-specific network, an over-long prefix, the
   // reserved verdict, the all-ones address and port, a zero address with a
   // prefix far above a full address, a zero prefix tied to one port, and a
   // catch-all rule at the end.
   task automatic test_fill_table();
      send_word(rule_word(0, 32'h0A00_0000, 6'd8, 16'd80, VERDICT_ACCEPT));
      send_word(rule_word(1, 32'h0A01_0203, 6'd40, 16'd0, VERDICT_REFUSE));
      send_word(rule_word(2, 32'hC0A8_0000, 6'd16, 16'd0, VERDICT_RESERVED));
      send_word(rule_word(3, 32'hFFFF_FFFF, 6'd32, 16'hFFFF, VERDICT_REFUSE));
      send_word(rule_word(4, 32'h0000_0000, 6'd63, 16'd1, VERDICT_ACCEPT));
      send_word(rule_word(5, 32'hAC10_0000, 6'd12, 16'd443, VERDICT_ACCEPT));
      send_word(rule_word(6, 32'hDEAD_BEEF, 6'd0, 16'd22, VERDICT_REFUSE));
      for (int slot = 7; slot < RULE_SLOTS - 1; slot++)
         send_word(rule_word(slot, $urandom, PREFIX_W'($urandom_range(32, 1)),
                             PORT_W'($urandom_range(1023, 1)), VERDICT_W'($urandom_range(3))));
      send_word(rule_word(RULE_SLOTS - 1, '0, '0, '0, VERDICT_ACCEPT));
   endtask

   // Directed lookups that land on the fixed rules in slots 0 to 4 and 6, then the count
   // extremes: above the table size, the largest code, and a single rule
   // that the target misses.
   task automatic test_first_match();
      write_rule_count(COUNT_W'(RULE_SLOTS));
      send_word(lookup_word(32'h0A05_0505, 16'd80));
      send_word(lookup_word(32'h0A01_0203, 16'd9));
      send_word(lookup_word(32'hC0A8_0707, 16'd5));
      send_word(lookup_word(32'hFFFF_FFFF, 16'hFFFF));
      send_word(lookup_word(32'h0000_0000, 16'd1));
      send_word(lookup_word(32'h0A05_0505, 16'd22));
      write_rule_count(COUNT_MAX);
      send_word(lookup_word(32'h0B00_0000, 16'd7));
      write_rule_count(COUNT_W'(RULE_SLOTS + 1));
      send_word(lookup_word(32'h0B00_0000, 16'd7));
      write_rule_count(COUNT_W'(1));
      send_word(lookup_word(32'h0B00_0000, 16'd80));
   endtask

   // Rounds of mixed writes and lookups, each under its own rule count.
   task automatic test_random_traffic();
      logic [COUNT_W-1:0] count;
      for (int round = 0; round < 9; round++) begin
         case (round)
            0:       count = '0;
            1:       count = COUNT_W'(RULE_SLOTS);
            2:       count = COUNT_MAX;
            3:       count = COUNT_W'($urandom_range(COUNT_MAX, RULE_SLOTS + 1));
            default: count = COUNT_W'($urandom_range(RULE_SLOTS, 1));
         endcase
         write_rule_count(count);
         repeat (100) send_word(random_word());
      end
   endtask

   // A long stretch where neither side idles.
   task automatic test_back_to_back();
      write_rule_count(COUNT_W'(RULE_SLOTS));
      burst_mode = 1'b1;
      repeat (200) send_word(random_word());
      wait_for_verdicts();
      burst_mode = 1'b0;
   endtask

   // Each word waits until the previous response has been taken.
   task automatic test_one_at_a_time();
      write_rule_count(COUNT_W'($urandom_range(RULE_SLOTS, 1)));
      repeat (50) begin
         send_word(random_word());
         wait_for_verdicts();
      end
   endtask

   // Response checker and receiver. Handshakes are sampled at the edge, and
   // ready for the next cycle is drawn at random, idling with a chance of IDLE_PERCENT
   // percent unless burst mode is on.
   always @(posedge clock) begin : check_verdicts
      verdict_word_type want;
      verdict_word_type got;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         got.verdict    = rsp_chan.verdict;
         got.matched    = rsp_chan.matched;
         got.match_slot = rsp_chan.match_slot;
         if (expected_verdicts.size() == 0) begin
            flag_failure($sformatf("unexpected word: verdict %0d matched %0d slot %0d",
                                   got.verdict, got.matched, got.match_slot));
         end else begin
            want = expected_verdicts.pop_front();
            if (got.verdict !== want.verdict || got.matched !== want.matched ||
                got.match_slot !== want.match_slot) begin
               flag_failure($sformatf(
                  "mismatch: expected verdict %0d matched %0d slot %0d, got %0d %0d %0d",
                  want.verdict, want.matched, want.match_slot,
                  got.verdict, got.matched, got.match_slot));
            end
         end
      end
      rsp_chan.ready <= burst_mode || ($urandom_range(99) >= IDLE_PERCENT);
   end

   // Main sequence: reset once, run each test in turn, then let the last
   // responses drain before judging the run.
   initial begin
      reset                   <= 1'b1;
      req_chan.valid          <= 1'b0;
      req_chan.kind           <= KIND_WRITE;
      req_chan.rule_slot      <= '0;
      req_chan.rule_address   <= '0;
      req_chan.rule_prefix    <= '0;
      req_chan.rule_port      <= '0;
      req_chan.rule_verdict   <= VERDICT_SKIP;
      req_chan.target_address <= '0;
      req_chan.dest_port      <= '0;
      csr_chan.valid          <= 1'b0;
      csr_chan.data           <= '0;
      shadow_count = '0;
      failures     = 0;
      burst_mode   = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_empty_table();
      test_fill_table();
      test_first_match();
      test_random_traffic();
      test_back_to_back();
      test_one_at_a_time();

      wait_for_verdicts();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_verdicts.size() != 0)
         flag_failure($sformatf("%0d expected words never arrived", expected_verdicts.size()));
      if (failures == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // A hung handshake ends the run here.
   initial begin
      #(TIMEOUT_UNITS);
      $display("Some tests failed");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/fmapf_pkg.sv
rtl/core/fmapf_channels.sv
rtl/core/fmapf_rule_match.sv
rtl/core/first_match_address_port_filter_core.sv
bench/tb_first_match_address_port_filter_core.sv
